// ===== src/hmth_pkg.sv =====
// ----------------------------------------------------------------------------
// hmth_pkg: shared types and constants of the heightmap height query
// Register indexes, field widths and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package hmth_pkg;

	localparam int COORD_W  = 18;
	localparam int HEIGHT_W = 16;
	localparam int RESULT_W = 24;
	localparam int SIDE_W   = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OUTSIDE_HEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS      = 2'd2;

	// request types
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// corners of the selected triangle: base, x neighbor, y neighbor
	typedef enum logic [1:0] {
		CORNER_BASE = 2'd0,
		CORNER_X    = 2'd1,
		CORNER_Y    = 2'd2
	} corner_t;

	typedef struct packed {
		logic    wr;       // store write_height at the input cell
		logic    load;     // latch cell and fraction of a query
		logic    rd;       // issue a memory read of one corner
		corner_t rd_sel;
		logic    cap;      // capture the corner read in the previous cycle
		corner_t cap_sel;
		logic    mul;      // form the two weighted differences
		logic    fin;      // sum, scale and saturate into the result register
	} dp_cmd_t;

endpackage

// ===== src/hmth_ram.sv =====
// ----------------------------------------------------------------------------
// hmth_ram: generic single-port RAM
// One write or one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module hmth_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== src/hmth_ctrl.sv =====
// ----------------------------------------------------------------------------
// hmth_ctrl: sequencer of the heightmap height query
// Accepts transactions and steps a query through three corner reads,
// the multiply step and the final sum.
// ----------------------------------------------------------------------------
module hmth_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              req_type,
	output logic              busy,
	output hmth_pkg::dp_cmd_t cmd
);
	import hmth_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RD_B = 7'b0000010,
		ST_RD_X = 7'b0000100,
		ST_RD_Y = 7'b0001000,
		ST_WAIT = 7'b0010000,
		ST_MUL  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.rd_sel  = CORNER_BASE;
		cmd.cap_sel = CORNER_BASE;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req_type == REQ_QUERY) begin
						cmd.load = 1'b1;
						state_d  = ST_RD_B;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_RD_B: begin
				cmd.rd     = 1'b1;
				cmd.rd_sel = CORNER_BASE;
				state_d    = ST_RD_X;
			end
			ST_RD_X: begin
				cmd.rd      = 1'b1;
				cmd.rd_sel  = CORNER_X;
				cmd.cap     = 1'b1;
				cmd.cap_sel = CORNER_BASE;
				state_d     = ST_RD_Y;
			end
			ST_RD_Y: begin
				cmd.rd      = 1'b1;
				cmd.rd_sel  = CORNER_Y;
				cmd.cap     = 1'b1;
				cmd.cap_sel = CORNER_X;
				state_d     = ST_WAIT;
			end
			ST_WAIT: begin
				cmd.cap     = 1'b1;
				cmd.cap_sel = CORNER_Y;
				state_d     = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_query_reaches_fin: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req_type == REQ_QUERY |=> ##5 cmd.fin)
		else $error("query did not reach the final step on time");

	a_cap_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |-> $past(cmd.rd))
		else $error("corner captured without a read in the previous cycle");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.wr && !cmd.load)
		else $error("transaction taken while a query is in flight");

endmodule

// ===== src/hmth_dp.sv =====
// ----------------------------------------------------------------------------
// hmth_dp: datapath of the heightmap height query
// Configuration registers, height memory, corner addressing and the
// interpolation arithmetic.
// ----------------------------------------------------------------------------
module hmth_dp #(
	parameter int CELL_SHIFT = 8,
	parameter int MAX_SIDE   = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  hmth_pkg::dp_cmd_t                      cmd,
	input  logic                                   cfg_we,
	input  logic        [hmth_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [hmth_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic signed [hmth_pkg::COORD_W-1:0]    coord_x,
	input  logic signed [hmth_pkg::COORD_W-1:0]    coord_y,
	input  logic signed [hmth_pkg::HEIGHT_W-1:0]   write_height,
	output logic signed [hmth_pkg::RESULT_W-1:0]   height_out,
	output logic                                   result_valid
);
	import hmth_pkg::*;

	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int AW     = $clog2(DEPTH);
	localparam int WW     = CELL_SHIFT + 1;
	localparam int DW     = HEIGHT_W + 1;
	localparam int PW     = DW + WW + 1;
	localparam int ACCW   = HEIGHT_W + CELL_SHIFT + 3;
	localparam int WIDEW  = ACCW + 8;
	localparam int RSH    = (CELL_SHIFT >= 8) ? CELL_SHIFT - 8 : 0;
	localparam int LSH    = (CELL_SHIFT < 8) ? 8 - CELL_SHIFT : 0;
	localparam int CW     = 20;
	localparam logic [WW-1:0] ONE = WW'(1 << CELL_SHIFT);
	localparam logic signed [WIDEW-1:0] SAT_HI = WIDEW'(8388607);
	localparam logic signed [WIDEW-1:0] SAT_LO = -WIDEW'(8388608);

	// configuration
	logic signed [HEIGHT_W-1:0] outside_q;
	logic        [SIDE_W-1:0]   columns_q, rows_q;
	logic        [SIDE_W-1:0]   cols_used, rows_used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outside_q <= '0;
			columns_q <= '0;
			rows_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OUTSIDE_HEIGHT: outside_q <= $signed(cfg_wdata[HEIGHT_W-1:0]);
				CFG_GRID_COLUMNS:   columns_q <= cfg_wdata[SIDE_W-1:0];
				CFG_GRID_ROWS:      rows_q    <= cfg_wdata[SIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the grid to the memory size
	assign cols_used = (32'(columns_q) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : columns_q;
	assign rows_used = (32'(rows_q) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : rows_q;

	// query cell and fraction
	logic signed [CW-1:0]         cx_q, cy_q;
	logic        [CELL_SHIFT-1:0] fx_q, fy_q;
	logic                         upper_q;
	logic        [WW-1:0]         fsum;

	assign fsum = WW'(coord_x[CELL_SHIFT-1:0]) + WW'(coord_y[CELL_SHIFT-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q    <= CW'(coord_x >>> CELL_SHIFT);
			cy_q    <= CW'(coord_y >>> CELL_SHIFT);
			fx_q    <= coord_x[CELL_SHIFT-1:0];
			fy_q    <= coord_y[CELL_SHIFT-1:0];
			upper_q <= fsum > ONE;
		end
	end

	// corner position; the base corner is the far one in the upper triangle
	logic signed [CW-1:0] ccol, crow;
	logic                 corner_ok;

	always_comb begin
		unique case (cmd.rd_sel)
			CORNER_BASE: begin
				ccol = upper_q ? cx_q + CW'(1) : cx_q;
				crow = upper_q ? cy_q + CW'(1) : cy_q;
			end
			CORNER_X: begin
				ccol = cx_q + CW'(1);
				crow = cy_q;
			end
			CORNER_Y: begin
				ccol = cx_q;
				crow = cy_q + CW'(1);
			end
			default: begin
				ccol = cx_q;
				crow = cy_q;
			end
		endcase
	end

	assign corner_ok = (ccol > CW'(0)) && (crow > CW'(0))
		&& (ccol < $signed({11'd0, cols_used})) && (crow < $signed({11'd0, rows_used}));

	// write range check
	logic wr_ok;
	assign wr_ok = (coord_x >= 0) && (coord_y >= 0)
		&& (coord_x < $signed({9'd0, cols_used})) && (coord_y < $signed({9'd0, rows_used}));

	// shared linear address: row * columns + column
	logic [SIDE_W-1:0]   arow, acol;
	logic [2*SIDE_W-1:0] aprod;
	logic [2*SIDE_W:0]   alin;
	logic [AW-1:0]       addr;

	always_comb begin
		if (cmd.wr) begin
			arow = coord_y[SIDE_W-1:0];
			acol = coord_x[SIDE_W-1:0];
		end else begin
			arow = crow[SIDE_W-1:0];
			acol = ccol[SIDE_W-1:0];
		end
	end

	assign aprod = arow * cols_used;
	assign alin  = (2*SIDE_W+1)'(aprod) + (2*SIDE_W+1)'(acol);
	assign addr  = AW'(alin);

	logic [HEIGHT_W-1:0] rdata;

	hmth_ram #(
		.WIDTH(HEIGHT_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr && wr_ok),
		.addr (addr),
		.wdata(write_height),
		.rdata(rdata)
	);

	// corner capture
	logic                       rd_ok_q;
	logic signed [HEIGHT_W-1:0] cval;
	logic signed [HEIGHT_W-1:0] hb_q, hx_q, hy_q;

	always_ff @(posedge clk) begin
		rd_ok_q <= corner_ok;
	end

	assign cval = rd_ok_q ? $signed(rdata) : outside_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			unique case (cmd.cap_sel)
				CORNER_BASE: hb_q <= cval;
				CORNER_X:    hx_q <= cval;
				CORNER_Y:    hy_q <= cval;
				default: ;
			endcase
		end
	end

	// weighted differences
	logic        [WW-1:0]  wx, wy;
	logic signed [DW-1:0]  dx, dy;
	logic signed [PW-1:0]  px_q, py_q;

	assign wx = upper_q ? ONE - WW'(fy_q) : WW'(fx_q);
	assign wy = upper_q ? ONE - WW'(fx_q) : WW'(fy_q);
	assign dx = DW'(hx_q) - DW'(hb_q);
	assign dy = DW'(hy_q) - DW'(hb_q);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			px_q <= PW'(dx) * $signed({1'b0, wx});
			py_q <= PW'(dy) * $signed({1'b0, wy});
		end
	end

	// sum, scale to 8 fraction bits (floor), saturate
	logic signed [ACCW-1:0]     acc;
	logic signed [WIDEW-1:0]    scaled;
	logic signed [RESULT_W-1:0] res;

	assign acc    = (ACCW'(hb_q) <<< CELL_SHIFT) + ACCW'(px_q) + ACCW'(py_q);
	assign scaled = (WIDEW'(acc) <<< LSH) >>> RSH;

	always_comb begin
		priority if (scaled > SAT_HI) begin
			res = RESULT_W'(SAT_HI);
		end else if (scaled < SAT_LO) begin
			res = RESULT_W'(SAT_LO);
		end else begin
			res = RESULT_W'(scaled);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			height_out <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.fin;
		end
	end

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(cmd.fin))
		else $error("result strobe without a final step");

endmodule

// ===== src/heightmap_triangle_height_query.sv =====
// ----------------------------------------------------------------------------
// heightmap_triangle_height_query: triangle-interpolated terrain height lookup
// A write stores one cell height; a query returns the interpolated height.
// ----------------------------------------------------------------------------
// Write: busy stays low; a write may follow every cycle.
// Query: busy from acceptance through the final sum; result_valid pulses for one cycle,
// registered from the final step. No new transaction is taken while busy, as a query
// steps through three corner reads through the single height memory port, the read
// latency, multiply and sum.
// Reset clears the configuration to zero; the height memory is not cleared.
module heightmap_triangle_height_query #(
	parameter int CELL_SHIFT = 8,
	parameter int MAX_SIDE   = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   req_type,
	input  logic signed [hmth_pkg::COORD_W-1:0]    coord_x,
	input  logic signed [hmth_pkg::COORD_W-1:0]    coord_y,
	input  logic signed [hmth_pkg::HEIGHT_W-1:0]   write_height,
	input  logic                                   cfg_we,
	input  logic        [hmth_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [hmth_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic signed [hmth_pkg::RESULT_W-1:0]   height_out,
	output logic                                   result_valid
);
	import hmth_pkg::*;

	dp_cmd_t cmd;

	hmth_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(req_type),
		.busy    (busy),
		.cmd     (cmd)
	);

	hmth_dp #(
		.CELL_SHIFT(CELL_SHIFT),
		.MAX_SIDE  (MAX_SIDE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.write_height(write_height),
		.height_out  (height_out),
		.result_valid(result_valid)
	);

endmodule

// ===== tb/tb_heightmap_triangle_height_query.sv =====
// ----------------------------------------------------------------------------
// tb_heightmap_triangle_height_query: self-checking bench for the height query
// Drives cell writes and position queries through the start/busy handshake,
// predicts every interpolated height in a scoreboard and compares each result
// strobe against it. Runs a directed set, then random phases over several grid
// sizes and outside heights with varying sender idle rates.
// ----------------------------------------------------------------------------
import hmth_pkg::*;

class terrain_height_scoreboard;
	localparam int CELL_SHIFT = 8;
	localparam int MAX_SIDE   = 256;
	localparam int ONE        = 1 << CELL_SHIFT;
	localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
	localparam int REPORT_MAX = 10;

	logic signed [HEIGHT_W-1:0] heights [DEPTH];
	bit                         known [DEPTH];
	logic signed [HEIGHT_W-1:0] outside_height;
	logic [SIDE_W-1:0]          grid_columns;
	logic [SIDE_W-1:0]          grid_rows;
	logic signed [RESULT_W-1:0] expected_heights [$];
	int                         mismatches;

	function new();
		outside_height = '0;
		grid_columns = '0;
		grid_rows = '0;
		mismatches = 0;
	endfunction

	function int cols_in_use();
		return (grid_columns > MAX_SIDE) ? MAX_SIDE : int'(grid_columns);
	endfunction

	function int rows_in_use();
		return (grid_rows > MAX_SIDE) ? MAX_SIDE : int'(grid_rows);
	endfunction

	function int pending();
		return expected_heights.size();
	endfunction

	function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_OUTSIDE_HEIGHT: outside_height = data;
			CFG_GRID_COLUMNS:   grid_columns = data[SIDE_W-1:0];
			CFG_GRID_ROWS:      grid_rows = data[SIDE_W-1:0];
			default: ;
		endcase
	endfunction

	function bit in_area(int col, int row);
		return col >= 1 && row >= 1 && col < cols_in_use() && row < rows_in_use();
	endfunction

	function longint corner_height(int col, int row);
		if (!in_area(col, row))
			return outside_height;
		return heights[row * cols_in_use() + col];
	endfunction

	function bit corner_known(int col, int row);
		return !in_area(col, row) || known[row * cols_in_use() + col];
	endfunction

	// floor division: the fraction never goes negative
	function void locate(int x, int y, output int cx, output int cy, output int fx,
			output int fy);
		fx = x & (ONE - 1);
		fy = y & (ONE - 1);
		cx = x >>> CELL_SHIFT;
		cy = y >>> CELL_SHIFT;
	endfunction

	// true when every corner the query reads is outside or was written
	function bit query_readable(int x, int y);
		int cx, cy, fx, fy;
		locate(x, y, cx, cy, fx, fy);
		if (fx + fy <= ONE)
			return corner_known(cx, cy) && corner_known(cx + 1, cy) && corner_known(cx, cy + 1);
		return corner_known(cx + 1, cy + 1) && corner_known(cx, cy + 1) &&
			corner_known(cx + 1, cy);
	endfunction

	function logic signed [RESULT_W-1:0] interpolate_height(int x, int y);
		int     cx, cy, fx, fy;
		longint b, c, hx, hy, acc, res;
		locate(x, y, cx, cy, fx, fy);
		if (fx + fy <= ONE) begin
			b  = corner_height(cx, cy);
			hx = corner_height(cx + 1, cy);
			hy = corner_height(cx, cy + 1);
			acc = b * ONE + (hx - b) * fx + (hy - b) * fy;
		end else begin
			c  = corner_height(cx + 1, cy + 1);
			hy = corner_height(cx, cy + 1);
			hx = corner_height(cx + 1, cy);
			acc = c * ONE + (hy - c) * (ONE - fx) + (hx - c) * (ONE - fy);
		end
		if (CELL_SHIFT >= 8)
			res = acc >>> (CELL_SHIFT - 8);
		else
			res = acc <<< (8 - CELL_SHIFT);
		if (res > 64'sd8388607)
			res = 64'sd8388607;
		if (res < -64'sd8388608)
			res = -64'sd8388608;
		return res[RESULT_W-1:0];
	endfunction

	function void note_item(logic req, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic signed [HEIGHT_W-1:0] h);
		int xi, yi, c, r;
		xi = x;
		yi = y;
		c = cols_in_use();
		r = rows_in_use();
		if (req == REQ_WRITE) begin
			if (xi >= 0 && yi >= 0 && xi < c && yi < r) begin
				heights[yi * c + xi] = h;
				known[yi * c + xi] = 1'b1;
			end
		end else begin
			expected_heights.push_back(interpolate_height(xi, yi));
		end
	endfunction

	function void check_height(logic signed [RESULT_W-1:0] actual);
		logic signed [RESULT_W-1:0] exp_h;
		if (expected_heights.size() == 0) begin
			if (mismatches < REPORT_MAX)
				$display("unexpected result transaction: height_out %0d", actual);
			mismatches++;
		end else begin
			exp_h = expected_heights.pop_front();
			if (actual !== exp_h) begin
				if (mismatches < REPORT_MAX)
					$display("height_out mismatch: expected %0d, got %0d", exp_h, actual);
				mismatches++;
			end
		end
	endfunction
endclass

module tb_heightmap_triangle_height_query;
	localparam int CELL_SHIFT    = 8;
	localparam int MAX_SIDE      = 256;
	localparam int ONE           = 1 << CELL_SHIFT;
	localparam int SETTLE_CYCLES = 10;
	localparam int STALL_LIMIT   = 2000;
	localparam int GAP_MAX       = 40;
	localparam int PHASE_ITEMS   = 65;
	localparam int PATCH_MAX     = 6;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         req_type;
	logic signed [COORD_W-1:0]    coord_x;
	logic signed [COORD_W-1:0]    coord_y;
	logic signed [HEIGHT_W-1:0]   write_height;
	logic                         cfg_we;
	logic [CFG_IDX_W-1:0]         cfg_index;
	logic [CFG_DATA_W-1:0]        cfg_wdata;
	logic signed [RESULT_W-1:0]   height_out;
	logic                         result_valid;

	terrain_height_scoreboard sb;
	int idle_pct;
	int stall_cycles;
	int patch_col, patch_row, patch_w, patch_h;

	heightmap_triangle_height_query #(
		.CELL_SHIFT(CELL_SHIFT),
		.MAX_SIDE(MAX_SIDE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.write_height(write_height),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.height_out(height_out),
		.result_valid(result_valid)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// check results before noting new transactions at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				sb.check_height(height_out);
			if (start && !busy)
				sb.note_item(req_type, coord_x, coord_y, write_height);
			if (cfg_we)
				sb.set_register(cfg_index, cfg_wdata);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || result_valid || cfg_we || (start && !busy)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_heightmap_triangle_height_query NOT OK");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic idle_gap();
		int n;
		n = 0;
		while (n < GAP_MAX && $urandom_range(99) < idle_pct)
			n++;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// leave start high on return so back-to-back transactions need no toggle
	task automatic send_item(logic req, int x, int y, int h);
		idle_gap();
		start <= 1'b1;
		req_type <= req;
		coord_x <= x[COORD_W-1:0];
		coord_y <= y[COORD_W-1:0];
		write_height <= h[HEIGHT_W-1:0];
		do @(posedge clk); while (busy);
	endtask

	// drain every pending query, then let a trailing write retire
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[CFG_DATA_W-1:0];
		@(posedge clk);
	endtask

	task automatic configure(int outside, int cols, int rows);
		wait_idle();
		write_register(CFG_OUTSIDE_HEIGHT, outside);
		write_register(CFG_GRID_COLUMNS, cols);
		write_register(CFG_GRID_ROWS, rows);
		cfg_we <= 1'b0;
	endtask

	function automatic int random_height();
		case ($urandom_range(7))
			0: return 32767;
			1: return -32768;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	function automatic int random_coord();
		return int'($urandom_range(262143)) - 131072;
	endfunction

	// write every cell of a small rectangle so that queries over it are readable
	task automatic fill_patch();
		int c, r, i, j;
		c = sb.cols_in_use();
		r = sb.rows_in_use();
		patch_w = (c < PATCH_MAX) ? c : PATCH_MAX;
		patch_h = (r < PATCH_MAX) ? r : PATCH_MAX;
		patch_col = $urandom_range(c - patch_w);
		patch_row = $urandom_range(r - patch_h);
		for (j = 0; j < patch_h; j++)
			for (i = 0; i < patch_w; i++)
				send_item(REQ_WRITE, patch_col + i, patch_row + j, random_height());
	endtask

	task automatic random_write();
		int c, r, x, y;
		c = sb.cols_in_use();
		r = sb.rows_in_use();
		case ($urandom_range(3))
			0, 1: begin
				x = patch_col + $urandom_range(patch_w);
				y = patch_row + $urandom_range(patch_h);
			end
			2: begin
				x = $urandom_range(c);
				y = $urandom_range(r);
			end
			default: begin
				x = random_coord();
				y = random_coord();
			end
		endcase
		send_item(REQ_WRITE, x, y, random_height());
	endtask

	task automatic random_query();
		int x, y, tries;
		bit ok;
		ok = 1'b0;
		for (tries = 0; tries < 8 && !ok; tries++) begin
			case ($urandom_range(3))
				0, 1: begin
					x = (patch_col + $urandom_range(patch_w)) * ONE + $urandom_range(ONE - 1);
					y = (patch_row + $urandom_range(patch_h)) * ONE + $urandom_range(ONE - 1);
				end
				2: begin
					// land on the diagonal shared by both triangles
					x = (patch_col + $urandom_range(patch_w)) * ONE + $urandom_range(ONE - 1);
					y = (patch_row + $urandom_range(patch_h)) * ONE +
						((ONE - (x & (ONE - 1))) & (ONE - 1));
				end
				default: begin
					x = random_coord();
					y = random_coord();
				end
			endcase
			ok = sb.query_readable(x, y);
		end
		// left of column zero every corner reads the outside height
		if (!ok) begin
			x = -int'($urandom_range(1, 131072));
			y = random_coord();
		end
		send_item(REQ_QUERY, x, y, random_height());
	endtask

	task automatic run_phase(int outside, int cols, int rows, int pct);
		configure(outside, cols, rows);
		idle_pct = pct;
		fill_patch();
		repeat (PHASE_ITEMS) begin
			if ($urandom_range(49) == 0)
				wait_idle();
			if ($urandom_range(99) < 40)
				random_write();
			else
				random_query();
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_WRITE;
		coord_x = '0;
		coord_y = '0;
		write_height = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_OUTSIDE_HEIGHT;
		cfg_wdata = '0;
		idle_pct = 20;
		stall_cycles = 0;
		patch_col = 0;
		patch_row = 0;
		patch_w = 0;
		patch_h = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty grid after reset: writes drop, every corner is outside
		send_item(REQ_QUERY, 0, 0, 0);
		send_item(REQ_WRITE, 0, 0, 4660);
		send_item(REQ_QUERY, 131071, 131071, -1);
		send_item(REQ_QUERY, -131072, -131072, 32767);

		configure(32767, 3, 3);
		send_item(REQ_WRITE, 1, 1, 32767);
		send_item(REQ_WRITE, 2, 1, -32768);
		send_item(REQ_WRITE, 1, 2, -32768);
		send_item(REQ_WRITE, 2, 2, 32767);
		send_item(REQ_WRITE, 0, 0, -1);
		// out of range writes: drop
		send_item(REQ_WRITE, 3, 1, 5);
		send_item(REQ_WRITE, 1, 3, 5);
		send_item(REQ_WRITE, -1, 1, 5);
		send_item(REQ_WRITE, 1, -131072, 5);
		send_item(REQ_QUERY, 256, 256, 0);
		send_item(REQ_QUERY, 384, 384, 0);
		send_item(REQ_QUERY, 385, 384, 0);
		send_item(REQ_QUERY, 511, 511, 0);
		send_item(REQ_QUERY, 767, 767, 0);
		send_item(REQ_QUERY, 300, 700, 0);
		send_item(REQ_QUERY, -1, -1, 0);
		send_item(REQ_QUERY, -131072, 131071, 0);
		send_item(REQ_QUERY, 131071, -1, 0);

		run_phase(-32768, 256, 256, 20);
		run_phase(int'($urandom_range(65535)) - 32768, 6, 5, 20);
		run_phase(int'($urandom_range(65535)) - 32768, 511, 2, 66);
		run_phase(int'($urandom_range(65535)) - 32768, 0, 256, 66);
		run_phase(int'($urandom_range(65535)) - 32768, 2 + $urandom_range(40),
			2 + $urandom_range(40), 0);
		run_phase(0, 256, 300, 0);

		wait_idle();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb_heightmap_triangle_height_query OK");
		else
			$display("tb_heightmap_triangle_height_query NOT OK");
		$finish;
	end
endmodule
